@@ design/ads_pkg.sv @@
// ----------------------------------------------------------------------------
// ads_pkg
// Shared constants for the antialiased disc stamp unit.
// ----------------------------------------------------------------------------
package ads_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 31;

  localparam int CFG_W   = 9;
  localparam int COORD_W = 11;
  localparam int PIX_W   = 8;
  localparam int RAD_W   = 9;
  localparam int SQ_W    = 19;   // 256 * (dx*dx + dy*dy), |dx|,|dy| <= 31

  // Register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_TABLE_RADIUS = 2'd2;

  // Transaction kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_STAMP = 2'd2;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [CFG_W-1:0] RST_TABLE_RADIUS = 9'd511;

  localparam logic [PIX_W-1:0] PIX_FULL = 8'hFF;

endpackage

@@ design/ads_store.sv @@
// ----------------------------------------------------------------------------
// ads_store
// Image memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ads_store
  import ads_pkg::*;
#(
  parameter int AW = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ads_ramp.sv @@
// ----------------------------------------------------------------------------
// ads_ramp
// Edge ramp value: bit-serial square root of the scaled distance, then a
// restoring divide giving 765*(R-W)/R rounded half up, clamped to 255.
// ----------------------------------------------------------------------------
module ads_ramp
  import ads_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SQ_W-1:0]  s,
  input  logic [RAD_W-1:0] r,
  output logic             done,
  output logic [PIX_W-1:0] q
);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_SQRT = 4'b0010,
    R_PREP = 4'b0100,
    R_DIV  = 4'b1000
  } ramp_state_t;

  ramp_state_t      state;
  logic [SQ_W-1:0]  s_r;
  logic [RAD_W-1:0] r_r;
  logic [RAD_W-1:0] res;
  logic [3:0]       cnt;
  logic [9:0]       rem;
  logic [9:0]       low;
  logic [9:0]       den;
  logic [9:0]       quo;

  logic [RAD_W-1:0] trial;
  logic [17:0]      trial_sq;
  logic [19:0]      num;
  logic [10:0]      rem_sh;

  assign trial    = res | (RAD_W'(1) << cnt);
  assign trial_sq = trial * trial;
  assign num      = 20'd1530 * 20'(r_r - res) + 20'(r_r);
  assign rem_sh   = {rem, low[9]};
  assign q        = (|quo[9:8]) ? PIX_FULL : quo[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        R_IDLE: begin
          if (start) begin
            s_r   <= s;
            r_r   <= r;
            res   <= '0;
            cnt   <= 4'd8;
            state <= R_SQRT;
          end
        end
        R_SQRT: begin
          if ({1'b0, trial_sq} <= s_r) begin
            res <= trial;
          end
          if (cnt == 4'd0) begin
            state <= R_PREP;
          end else begin
            cnt <= cnt - 4'd1;
          end
        end
        R_PREP: begin
          rem   <= num[19:10];
          low   <= num[9:0];
          den   <= {r_r, 1'b0};
          quo   <= '0;
          cnt   <= 4'd9;
          state <= R_DIV;
        end
        R_DIV: begin
          if (rem_sh >= {1'b0, den}) begin
            rem <= 10'(rem_sh - {1'b0, den});
            quo <= {quo[8:0], 1'b1};
          end else begin
            rem <= rem_sh[9:0];
            quo <= {quo[8:0], 1'b0};
          end
          low <= {low[8:0], 1'b0};
          if (cnt == 4'd0) begin
            done  <= 1'b1;
            state <= R_IDLE;
          end else begin
            cnt <= cnt - 4'd1;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

@@ design/antialiased_disc_stamp_unit.sv @@
// ----------------------------------------------------------------------------
// antialiased_disc_stamp_unit
// Grey image store with pixel write, pixel read and antialiased disc stamp.
// ----------------------------------------------------------------------------
// Issue a transaction by raising start while busy is low. Each transaction
// returns exactly one result: done is high for a single cycle with
// read_value and out_of_range, and the receiver cannot stall it, so sample
// it in that cycle. After reset the unit clears the image memory (65536
// pixels by default), one pixel per cycle, with busy high; configuration
// writes are taken during that pass. A pixel write passes through S_ADDR
// and S_RWACT, a read also through S_RDWAIT. A stamp scans the square of
// side 2h+1, h = min(min(radius, table_radius)/16, MAX_RADIUS), one offset
// at a time through the single image memory: a skipped or solid-core offset
// passes through S_VISIT, S_TEST and S_ACT; a ramp pixel then also waits in
// S_RAMP for the ramp unit, whose square root (9 steps) and divide (10
// steps) run one bit per cycle. Write configuration only while busy is low.
// ----------------------------------------------------------------------------
module antialiased_disc_stamp_unit
  import ads_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                kind,
  input  logic signed [COORD_W-1:0] pos_x,
  input  logic signed [COORD_W-1:0] pos_y,
  input  logic [PIX_W-1:0]          pixel_value,
  input  logic [RAD_W-1:0]          radius,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output logic                      done,
  output logic [PIX_W-1:0]          read_value,
  output logic                      out_of_range
);

  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  // The scan half width never exceeds 31 (a 9-bit radius over 16).
  localparam int HR = (MAX_RADIUS < 31) ? MAX_RADIUS : 31;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_ADDR   = 9'b000000100,
    S_RWACT  = 9'b000001000,
    S_RDWAIT = 9'b000010000,
    S_VISIT  = 9'b000100000,
    S_TEST   = 9'b001000000,
    S_ACT    = 9'b010000000,
    S_RAMP   = 9'b100000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CFG_W-1:0] table_radius;

  // Transaction registers
  logic [1:0]                kind_r;
  logic [PIX_W-1:0]          val_r;
  logic [RAD_W-1:0]          rad_r;
  logic [17:0]               rr;
  logic [17:0]               tt;
  logic signed [COORD_W-1:0] cx;
  logic signed [COORD_W-1:0] cy;
  logic signed [6:0]         half;
  logic signed [6:0]         dx;
  logic signed [6:0]         dy;
  logic signed [COORD_W:0]   px;
  logic signed [COORD_W:0]   py;
  logic [10:0]               d2;
  logic [AW-1:0]             addr_r;
  logic                      inside_r;
  logic                      ok_r;
  logic                      core_r;
  logic [AW-1:0]             clr_cnt;

  // Memory and ramp connections
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [PIX_W-1:0] mem_wdata;
  logic             mem_re;
  logic [PIX_W-1:0] mem_rdata;
  logic             ramp_start;
  logic             ramp_done;
  logic [PIX_W-1:0] ramp_q;

  logic [12:0]       eff_w;
  logic [12:0]       eff_h;
  logic              in_image;
  logic [23:0]       addr_full;
  logic [SQ_W-1:0]   s;
  logic [RAD_W-1:0]  lim;
  logic [4:0]        lim_h;
  logic signed [13:0] sqx;
  logic signed [13:0] sqy;
  logic              adv;

  // Widths above the build limit act as the limit.
  assign eff_w = ({4'b0, image_width} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {4'b0, image_width};
  assign eff_h = ({4'b0, image_height} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT)
                                                           : {4'b0, image_height};

  assign in_image = !px[COORD_W] && !py[COORD_W]
                 && ({1'b0, px} < {1'b0, eff_w}) && ({1'b0, py} < {1'b0, eff_h});
  assign addr_full = 24'(py[COORD_W-1:0]) * 24'(eff_w) + 24'(px[COORD_W-1:0]);

  assign s     = {d2, 8'b0};
  assign lim   = (radius < table_radius) ? radius : table_radius;
  assign lim_h = lim[8:4];
  assign sqx   = dx * dx;
  assign sqy   = dy * dy;

  assign busy = (state != S_IDLE);

  // Memory port steering
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = addr_r;
    mem_wdata  = PIX_FULL;
    mem_re     = 1'b0;
    ramp_start = 1'b0;
    adv        = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_RWACT: begin
        mem_we    = inside_r && (kind_r == KIND_WRITE);
        mem_wdata = val_r;
        mem_re    = inside_r && (kind_r == KIND_READ);
      end
      S_ACT: begin
        if (!ok_r) begin
          adv = 1'b1;
        end else if (core_r) begin
          mem_we = 1'b1;
          adv    = 1'b1;
        end else begin
          mem_re     = 1'b1;
          ramp_start = 1'b1;
        end
      end
      S_RAMP: begin
        // Max blend: keep the old pixel unless the ramp value is larger.
        mem_wdata = ramp_q;
        mem_we    = ramp_done && (mem_rdata < ramp_q);
        adv       = ramp_done;
      end
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      table_radius <= RST_TABLE_RADIUS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        CFG_TABLE_RADIUS: table_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      done         <= 1'b0;
      read_value   <= '0;
      out_of_range <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (&clr_cnt) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            kind_r <= kind;
            val_r  <= pixel_value;
            rad_r  <= radius;
            rr     <= radius * radius;
            tt     <= table_radius * table_radius;
            cx     <= pos_x;
            cy     <= pos_y;
            px     <= {pos_x[COORD_W-1], pos_x};
            py     <= {pos_y[COORD_W-1], pos_y};
            half   <= ({2'b0, lim_h} > 7'(HR)) ? 7'(HR) : {2'b0, lim_h};
            dx     <= -(({2'b0, lim_h} > 7'(HR)) ? 7'(HR) : {2'b0, lim_h});
            dy     <= -(({2'b0, lim_h} > 7'(HR)) ? 7'(HR) : {2'b0, lim_h});
            if (kind == KIND_STAMP) begin
              state <= S_VISIT;
            end else if (kind == KIND_WRITE || kind == KIND_READ) begin
              state <= S_ADDR;
            end else begin
              // Unused kind: answer with zeros, touch nothing.
              done         <= 1'b1;
              read_value   <= '0;
              out_of_range <= 1'b0;
            end
          end
        end
        S_ADDR: begin
          inside_r <= in_image;
          addr_r   <= addr_full[AW-1:0];
          state    <= S_RWACT;
        end
        S_RWACT: begin
          if (inside_r && kind_r == KIND_READ) begin
            state <= S_RDWAIT;
          end else begin
            done         <= 1'b1;
            read_value   <= '0;
            out_of_range <= !inside_r;
            state        <= S_IDLE;
          end
        end
        S_RDWAIT: begin
          done         <= 1'b1;
          read_value   <= mem_rdata;
          out_of_range <= 1'b0;
          state        <= S_IDLE;
        end
        S_VISIT: begin
          px    <= {cx[COORD_W-1], cx} + (COORD_W+1)'(dx);
          py    <= {cy[COORD_W-1], cy} + (COORD_W+1)'(dy);
          d2    <= 11'(sqx + sqy);
          state <= S_TEST;
        end
        S_TEST: begin
          ok_r   <= ({1'b0, s} <= {2'b0, rr}) && ({1'b0, s} <= {2'b0, tt}) && in_image;
          core_r <= (23'(s) * 23'd9) <= {3'b0, rr, 2'b0};
          addr_r <= addr_full[AW-1:0];
          state  <= S_ACT;
        end
        S_ACT: begin
          if (!adv) begin
            state <= S_RAMP;
          end
        end
        default: ;
      endcase

      // Advance the scan: next column, then next row, then finish.
      if (adv) begin
        if (dx == half) begin
          dx <= -half;
          if (dy == half) begin
            done         <= 1'b1;
            read_value   <= '0;
            out_of_range <= 1'b0;
            state        <= S_IDLE;
          end else begin
            dy    <= dy + 7'sd1;
            state <= S_VISIT;
          end
        end else begin
          dx    <= dx + 7'sd1;
          state <= S_VISIT;
        end
      end
    end
  end

  ads_store #(
    .AW(AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  ads_ramp u_ramp (
    .clk   (clk),
    .rst   (rst),
    .start (ramp_start),
    .s     (s),
    .r     (rad_r),
    .done  (ramp_done),
    .q     (ramp_q)
  );

endmodule

@@ tb/tb_antialiased_disc_stamp_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_antialiased_disc_stamp_unit
// Self-checking bench: pixel writes, reads and disc stamps against an image
// mirror kept in the bench, under several image and table radius settings.
// ----------------------------------------------------------------------------
module tb_antialiased_disc_stamp_unit;
  import ads_pkg::*;

  localparam int IMG_PIXELS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] kind;
    int         x;
    int         y;
    int         val;
    int         rad;
    bit         typed;  // expected reply typed in below
    int         rv;
    bit         oor;
  } plan_row_t;

  typedef struct {
    logic [PIX_W-1:0] value;
    logic             oor;
  } reply_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [1:0]                kind;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic [PIX_W-1:0]          pixel_value;
  logic [RAD_W-1:0]          radius;
  logic                      cfg_we;
  logic [1:0]                cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  logic                      done;
  logic [PIX_W-1:0]          read_value;
  logic                      out_of_range;

  // Mirror of the block: image memory plus register copies
  logic [PIX_W-1:0] image_mirror [IMG_PIXELS];
  int               img_width;
  int               img_height;
  int               tbl_radius;

  reply_t    awaited_replies [$];
  plan_row_t directed_plan [$];
  int        mismatch_count;
  int        issued_count;
  int        stamp_count;
  int        reply_count;
  bit        no_gaps;

  antialiased_disc_stamp_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pixel_value  (pixel_value),
    .radius       (radius),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .done         (done),
    .read_value   (read_value),
    .out_of_range (out_of_range)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run, clearing pass included
  initial begin
    #1_000_000_000;
    $display("antialiased_disc_stamp_unit test failed");
    $finish;
  end

  function automatic int eff_width();
    return (img_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : img_width;
  endfunction

  function automatic int eff_height();
    return (img_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : img_height;
  endfunction

  function automatic bit on_image(int x, int y);
    return x >= 0 && y >= 0 && x < eff_width() && y < eff_height();
  endfunction

  // Bitwise integer square root, result fits in 10 bits
  function automatic int int_sqrt(int v);
    int r;
    int t;
    r = 0;
    for (int b = 9; b >= 0; b--) begin
      t = r | (1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Paint one disc into the mirror with max blend on the ramp
  function automatic void paint_disc(int cx, int cy, int rr);
    int lim;
    int half;
    int s;
    int x;
    int y;
    int a;
    int ramp_dist;
    int q;
    lim  = (rr < tbl_radius) ? rr : tbl_radius;
    half = lim >> 4;
    if (half > DEF_MAX_RADIUS) half = DEF_MAX_RADIUS;
    for (int dy = -half; dy <= half; dy++) begin
      for (int dx = -half; dx <= half; dx++) begin
        s = 256 * (dx * dx + dy * dy);
        x = cx + dx;
        y = cy + dy;
        if (s > rr * rr || s > tbl_radius * tbl_radius) continue;
        if (!on_image(x, y)) continue;
        a = y * eff_width() + x;
        if (9 * s <= 4 * rr * rr) begin
          image_mirror[a] = PIX_FULL;
          continue;
        end
        if (rr == 0) continue;
        ramp_dist = int_sqrt(s);
        if (ramp_dist > rr) ramp_dist = rr;
        q = (1530 * (rr - ramp_dist) + rr) / (2 * rr);
        if (q > 255) q = 255;
        if (image_mirror[a] < q) image_mirror[a] = q[PIX_W-1:0];
      end
    end
  endfunction

  // Apply one accepted transaction to the mirror and return its reply
  function automatic reply_t apply_transaction(logic [1:0] k, int x, int y, int v, int rr);
    reply_t rep;
    rep.value = '0;
    rep.oor   = 1'b0;
    case (k)
      KIND_WRITE: begin
        if (on_image(x, y)) image_mirror[y * eff_width() + x] = v[PIX_W-1:0];
        else rep.oor = 1'b1;
      end
      KIND_READ: begin
        if (on_image(x, y)) rep.value = image_mirror[y * eff_width() + x];
        else rep.oor = 1'b1;
      end
      KIND_STAMP: paint_disc(x, y, rr);
      default: ;
    endcase
    return rep;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Check every reply strobe against the oldest awaited reply
  always @(posedge clk) begin
    reply_t want;
    if (!rst && done) begin
      reply_count++;
      if (awaited_replies.size() == 0) begin
        report_mismatch("reply with nothing outstanding");
      end else begin
        want = awaited_replies.pop_front();
        if (read_value !== want.value)
          report_mismatch($sformatf("read_value %0d, want %0d", read_value, want.value));
        if (out_of_range !== want.oor)
          report_mismatch($sformatf("out_of_range %0b, want %0b", out_of_range, want.oor));
      end
    end
  end

  // Hold start with the transaction until it is taken, then predict
  task automatic issue(logic [1:0] k, int x, int y, int v, int rr, bit typed,
                       int rv, bit oor);
    reply_t rep;
    start       <= 1'b1;
    kind        <= k;
    pos_x       <= x[COORD_W-1:0];
    pos_y       <= y[COORD_W-1:0];
    pixel_value <= v[PIX_W-1:0];
    radius      <= rr[RAD_W-1:0];
    do @(posedge clk); while (busy);
    rep = apply_transaction(k, $signed(x[COORD_W-1:0]), $signed(y[COORD_W-1:0]),
                            v & 8'hFF, rr & 9'h1FF);
    if (typed) begin
      rep.value = rv[PIX_W-1:0];
      rep.oor   = oor;
    end
    awaited_replies.push_back(rep);
    issued_count++;
    if (k == KIND_STAMP) stamp_count++;
    // Drop start for a random gap now and then
    if (!no_gaps && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drain, let the block settle, then write all three registers
  task automatic set_config(int w, int h, int t);
    start <= 1'b0;
    @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_IMAGE_WIDTH;  cfg_data <= w[CFG_W-1:0];
    @(posedge clk); img_width = w;
    cfg_index <= CFG_IMAGE_HEIGHT; cfg_data <= h[CFG_W-1:0];
    @(posedge clk); img_height = h;
    cfg_index <= CFG_TABLE_RADIUS; cfg_data <= t[CFG_W-1:0];
    @(posedge clk); tbl_radius = t;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_row(logic [1:0] k, int x, int y, int v, int rr,
                                  bit typed = 0, int rv = 0, bit oor = 0);
    plan_row_t r;
    r.kind = k; r.x = x; r.y = y; r.val = v; r.rad = rr;
    r.typed = typed; r.rv = rv; r.oor = oor;
    directed_plan.push_back(r);
  endfunction

  // Random coordinate: mostly around the used image, sometimes anywhere
  function automatic int pick_coord(int span);
    if ($urandom_range(0, 9) == 0) return int'($signed(11'($urandom_range(0, 2047))));
    return $urandom_range(0, span + 16) - 8;
  endfunction

  function automatic int pick_radius();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return $urandom_range(0, 96);
    if (roll < 97) return $urandom_range(97, 200);
    return $urandom_range(0, 511);
  endfunction

  task automatic random_phase(int n);
    int roll;
    int w;
    int h;
    logic [1:0] k;
    w = eff_width();
    h = eff_height();
    for (int i = 0; i < n; i++) begin
      no_gaps = (i >= 8 && i < 20);
      roll = $urandom_range(0, 99);
      if (roll < 40)      k = KIND_STAMP;
      else if (roll < 75) k = KIND_READ;
      else if (roll < 95) k = KIND_WRITE;
      else                k = KIND_UNUSED;
      issue(k, pick_coord(w), pick_coord(h), $urandom_range(0, 255), pick_radius(),
            0, 0, 0);
    end
    no_gaps = 0;
  endtask

  initial begin
    int settings [5][3];
    rst = 1'b1; start = 1'b0; kind = KIND_WRITE; pos_x = '0; pos_y = '0;
    pixel_value = '0; radius = '0; cfg_we = 1'b0; cfg_index = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    mismatch_count = 0; issued_count = 0; stamp_count = 0; reply_count = 0;
    no_gaps = 0;
    foreach (image_mirror[i]) image_mirror[i] = '0;
    img_width = RST_IMAGE_WIDTH; img_height = RST_IMAGE_HEIGHT;
    tbl_radius = RST_TABLE_RADIUS;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // Wait out the clearing pass
    @(posedge clk);
    while (busy) @(posedge clk);

    // Directed part under reset settings
    add_row(KIND_READ,    0,    0,   0,   0, 1, 0, 0);
    add_row(KIND_READ,  255,  255,   0,   0, 1, 0, 0);
    add_row(KIND_READ,  256,    0,   0,   0, 1, 0, 1);
    add_row(KIND_READ,   -1,    0,   0,   0, 1, 0, 1);
    add_row(KIND_WRITE,   0,    0, 255,   0, 1, 0, 0);
    add_row(KIND_READ,    0,    0,   0,   0, 1, 255, 0);
    add_row(KIND_WRITE, -1024, 1023, 170, 0, 1, 0, 1);
    add_row(KIND_READ,  1023, -1024, 0,   0, 1, 0, 1);
    add_row(KIND_STAMP,  10,   10,   0,   0, 1, 0, 0);
    add_row(KIND_READ,   10,   10,   0,   0, 1, 255, 0);
    add_row(KIND_READ,   11,   10,   0,   0);
    add_row(KIND_STAMP, 100,  100,  85, 160);
    add_row(KIND_READ,  100,  100,   0,   0, 1, 255, 0);
    add_row(KIND_READ,  108,  100,   0,   0);
    add_row(KIND_READ,  106,  105,   0,   0);
    add_row(KIND_STAMP,  -5,   -5,   0, 100);
    add_row(KIND_READ,    0,    0,   0,   0);
    add_row(KIND_UNUSED, 20,   20, 255, 511, 1, 0, 0);
    add_row(KIND_WRITE, 255,  255,   0,   0, 1, 0, 0);
    add_row(KIND_STAMP, 250,  250,   0, 511);
    add_row(KIND_READ,  255,  255,   0,   0, 1, 255, 0);
    add_row(KIND_READ,  220,  250,   0,   0);
    add_row(KIND_STAMP, 1023, 1023,  0, 511);
    foreach (directed_plan[i])
      issue(directed_plan[i].kind, directed_plan[i].x, directed_plan[i].y,
            directed_plan[i].val, directed_plan[i].rad, directed_plan[i].typed,
            directed_plan[i].rv, directed_plan[i].oor);

    // Random phases across register settings, extremes included
    settings = '{'{40, 30, 511}, '{0, 20, 100}, '{511, 1, 0},
                 '{1, 256, 48}, '{17, 511, 300}};
    foreach (settings[p]) begin
      set_config(settings[p][0], settings[p][1], settings[p][2]);
      random_phase(20);
    end
    set_config(256, 256, 511);
    random_phase(20);

    start <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (awaited_replies.size() != 0) report_mismatch("replies still outstanding");

    $display("Covered %0d transactions (%0d stamps), %0d replies checked, %0d mismatches.",
             issued_count, stamp_count, reply_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("antialiased_disc_stamp_unit test passed");
    end else begin
      $display("antialiased_disc_stamp_unit test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ads_pkg.sv
design/ads_store.sv
design/ads_ramp.sv
design/antialiased_disc_stamp_unit.sv
tb/tb_antialiased_disc_stamp_unit.sv
